### sv/hcr_pkg.sv
// Shared types and constants for the height color ramp.
package hcr_pkg;

    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int NUM_CHAN = 3;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_HEIGHT_MIN = 3'd0;
    localparam cfg_idx_t REG_HEIGHT_MAX = 3'd1;
    localparam cfg_idx_t REG_COLOR_LOW  = 3'd2;
    localparam cfg_idx_t REG_COLOR_MID  = 3'd3;
    localparam cfg_idx_t REG_COLOR_HIGH = 3'd4;

    localparam logic [COLOR_W-1:0] COLOR_LOW_RST  = 24'h0000FF;
    localparam logic [COLOR_W-1:0] COLOR_MID_RST  = 24'h00FF00;
    localparam logic [COLOR_W-1:0] COLOR_HIGH_RST = 24'hFF0000;

    typedef struct packed {
        logic [COLOR_W-1:0] low;
        logic [COLOR_W-1:0] mid;
        logic [COLOR_W-1:0] high;
    } ramp_colors_t;

    // zero: quotient forced to 0 (equal limits or opposite signs)
    // sat:  quotient clamps to the top of the ramp
    typedef struct packed {
        logic zero;
        logic sat;
    } div_flags_t;

endpackage

### sv/height_color_ramp.sv
// Items pass front stages, the FRAC_BITS+1 stage restoring divider and blend stages.
// Throughput: one item per cycle without back pressure; the divider sets the depth.
// Each stage holds its item under back pressure; empty stages still take new items.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register reset values.
// Configuration writes are taken every cycle.
module height_color_ramp #(
    parameter int HEIGHT_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((HEIGHT_BITS+7)/8)*8-1:0]    s_tdata,  // [HEIGHT_BITS-1:0] height
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hcr_pkg::COLOR_W-1:0]         m_tdata,  // [23:0] rgb
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  hcr_pkg::cfg_idx_t                   cfg_index,
    input  logic [(((HEIGHT_BITS > 24) ? HEIGHT_BITS : 24)+7)/8*8-1:0] cfg_data
);
    import hcr_pkg::*;

    localparam int CFG_RAW = (HEIGHT_BITS > COLOR_W) ? HEIGHT_BITS : COLOR_W;
    localparam int CFG_W   = (CFG_RAW + 7) / 8 * 8;

    logic [HEIGHT_BITS-1:0] height_min;
    logic [HEIGHT_BITS-1:0] height_max;
    ramp_colors_t           colors;

    logic                   fr_valid;
    logic                   fr_ready;
    logic [HEIGHT_BITS-1:0] fr_rem;
    logic [HEIGHT_BITS-1:0] fr_div;
    div_flags_t             fr_flags;

    logic                   dv_valid;
    logic                   dv_ready;
    logic [FRAC_BITS:0]     dv_quo;
    div_flags_t             dv_flags;

    hcr_cfg #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .CFG_W       (CFG_W)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .height_min (height_min),
        .height_max (height_max),
        .colors     (colors)
    );

    hcr_front #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_height  (s_tdata[HEIGHT_BITS-1:0]),
        .height_min (height_min),
        .height_max (height_max),
        .out_valid  (fr_valid),
        .out_ready  (fr_ready),
        .out_rem    (fr_rem),
        .out_div    (fr_div),
        .out_flags  (fr_flags)
    );

    hcr_div_chain #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_rem    (fr_rem),
        .in_div    (fr_div),
        .in_flags  (fr_flags),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_quo   (dv_quo),
        .out_flags (dv_flags)
    );

    hcr_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_quo    (dv_quo),
        .in_flags  (dv_flags),
        .colors    (colors),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rgb   (m_tdata)
    );

endmodule

### sv/hcr_cfg.sv
// Configuration register file for the color ramp.
module hcr_cfg #(
    parameter int HEIGHT_BITS = 16,
    parameter int CFG_W = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  hcr_pkg::cfg_idx_t       cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    output logic [HEIGHT_BITS-1:0]  height_min,
    output logic [HEIGHT_BITS-1:0]  height_max,
    output hcr_pkg::ramp_colors_t   colors
);
    import hcr_pkg::*;

    logic [HEIGHT_BITS-1:0] height_min_reg;
    logic [HEIGHT_BITS-1:0] height_max_reg;
    ramp_colors_t           colors_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_min_reg  <= '0;
            height_max_reg  <= '0;
            colors_reg.low  <= COLOR_LOW_RST;
            colors_reg.mid  <= COLOR_MID_RST;
            colors_reg.high <= COLOR_HIGH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_HEIGHT_MIN: height_min_reg  <= cfg_data[HEIGHT_BITS-1:0];
                REG_HEIGHT_MAX: height_max_reg  <= cfg_data[HEIGHT_BITS-1:0];
                REG_COLOR_LOW:  colors_reg.low  <= cfg_data[COLOR_W-1:0];
                REG_COLOR_MID:  colors_reg.mid  <= cfg_data[COLOR_W-1:0];
                REG_COLOR_HIGH: colors_reg.high <= cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign height_min = height_min_reg;
    assign height_max = height_max_reg;
    assign colors     = colors_reg;

endmodule

### sv/hcr_front.sv
// Front stages: offsets from the ramp start, magnitudes, sign and clamp flags.
module hcr_front #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [HEIGHT_BITS-1:0]  in_height,
    input  logic [HEIGHT_BITS-1:0]  height_min,
    input  logic [HEIGHT_BITS-1:0]  height_max,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [HEIGHT_BITS-1:0]  out_rem,
    output logic [HEIGHT_BITS-1:0]  out_div,
    output hcr_pkg::div_flags_t     out_flags
);
    import hcr_pkg::*;

    localparam int H = HEIGHT_BITS;

    logic [H:0]   diff;
    logic [H:0]   span;
    logic [H:0]   diff_abs;
    logic [H:0]   span_abs;
    logic         zero_next;

    logic         v1_reg;
    logic         ready1;
    logic [H-1:0] mag_d_reg;
    logic [H-1:0] mag_s_reg;
    logic         zero_reg;

    logic         v2_reg;
    logic         ready2;
    logic [H-1:0] rem_reg;
    logic [H-1:0] div_reg;
    div_flags_t   flags_reg;
    logic         sat_next;

    assign diff = {in_height[H-1], in_height} - {height_min[H-1], height_min};
    assign span = {height_max[H-1], height_max} - {height_min[H-1], height_min};
    assign diff_abs = diff[H] ? (~diff + {{H{1'b0}}, 1'b1}) : diff;
    assign span_abs = span[H] ? (~span + {{H{1'b0}}, 1'b1}) : span;
    // equal limits, or offset and span of opposite sign: the ramp position is 0
    assign zero_next = (span == '0) || ((diff != '0) && (diff[H] != span[H]));

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ready1) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && in_valid) begin
            mag_d_reg <= diff_abs[H-1:0];
            mag_s_reg <= span_abs[H-1:0];
            zero_reg  <= zero_next;
        end
    end

    assign sat_next = (mag_d_reg >= mag_s_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ready2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready2 && v1_reg) begin
            rem_reg        <= mag_d_reg;
            div_reg        <= mag_s_reg;
            flags_reg.zero <= zero_reg;
            flags_reg.sat  <= sat_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_flags = flags_reg;

endmodule

### sv/hcr_div_step.sv
// One restoring division step: one quotient bit per stage.
module hcr_div_step #(
    parameter int HEIGHT_BITS = 16,
    parameter int Q_BITS = 17
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [HEIGHT_BITS-1:0]  in_rem,
    input  logic [HEIGHT_BITS-1:0]  in_div,
    input  logic [Q_BITS-1:0]       in_quo,
    input  hcr_pkg::div_flags_t     in_flags,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [HEIGHT_BITS-1:0]  out_rem,
    output logic [HEIGHT_BITS-1:0]  out_div,
    output logic [Q_BITS-1:0]       out_quo,
    output hcr_pkg::div_flags_t     out_flags
);
    import hcr_pkg::*;

    localparam int H = HEIGHT_BITS;

    logic [H:0]          rem_dbl;
    logic [H:0]          rem_sub;
    logic                q_bit;
    logic [H-1:0]        rem_next;
    logic [Q_BITS-1:0]   quo_next;

    logic                valid_reg;
    logic [H-1:0]        rem_reg;
    logic [H-1:0]        div_reg;
    logic [Q_BITS-1:0]   quo_reg;
    div_flags_t          flags_reg;

    // remainder stays below the divisor unless the item already saturated
    assign rem_dbl  = {in_rem, 1'b0};
    assign rem_sub  = rem_dbl - {1'b0, in_div};
    assign q_bit    = (rem_dbl >= {1'b0, in_div});
    assign rem_next = q_bit ? rem_sub[H-1:0] : rem_dbl[H-1:0];
    assign quo_next = {in_quo[Q_BITS-2:0], q_bit};

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rem_reg   <= rem_next;
            div_reg   <= in_div;
            quo_reg   <= quo_next;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_quo   = quo_reg;
    assign out_flags = flags_reg;

endmodule

### sv/hcr_div_chain.sv
// Pipelined divider: FRAC_BITS+1 restoring steps give the ramp fraction.
module hcr_div_chain #(
    parameter int HEIGHT_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [HEIGHT_BITS-1:0]  in_rem,
    input  logic [HEIGHT_BITS-1:0]  in_div,
    input  hcr_pkg::div_flags_t     in_flags,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [FRAC_BITS:0]      out_quo,
    output hcr_pkg::div_flags_t     out_flags
);
    import hcr_pkg::*;

    localparam int Q_BITS = FRAC_BITS + 1;
    localparam int STEPS  = FRAC_BITS + 1;

    logic                   vld   [STEPS+1];
    logic                   rdy   [STEPS+1];
    logic [HEIGHT_BITS-1:0] rem   [STEPS+1];
    logic [HEIGHT_BITS-1:0] dvs   [STEPS+1];
    logic [Q_BITS-1:0]      quo   [STEPS+1];
    div_flags_t             flg   [STEPS+1];

    assign vld[0]   = in_valid;
    assign in_ready = rdy[0];
    assign rem[0]   = in_rem;
    assign dvs[0]   = in_div;
    assign quo[0]   = '0;
    assign flg[0]   = in_flags;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        hcr_div_step #(
            .HEIGHT_BITS (HEIGHT_BITS),
            .Q_BITS      (Q_BITS)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_rem    (rem[i]),
            .in_div    (dvs[i]),
            .in_quo    (quo[i]),
            .in_flags  (flg[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_rem   (rem[i+1]),
            .out_div   (dvs[i+1]),
            .out_quo   (quo[i+1]),
            .out_flags (flg[i+1])
        );
    end

    assign rdy[STEPS] = out_ready;
    assign out_valid  = vld[STEPS];
    assign out_quo    = quo[STEPS];
    assign out_flags  = flg[STEPS];

endmodule

### sv/hcr_blend.sv
// Blend stages: stop selection, per-channel products, sum and output register.
module hcr_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [FRAC_BITS:0]          in_quo,
    input  hcr_pkg::div_flags_t         in_flags,
    input  hcr_pkg::ramp_colors_t       colors,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [hcr_pkg::COLOR_W-1:0] out_rgb
);
    import hcr_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int PROD_W = CHAN_W + F + 1;

    // stage 1: ramp position, half select, weights
    logic [F+1:0]       q;
    logic               upper;
    logic [F:0]         w_next;
    logic [F+1:0]       wi_full;

    logic               v1_reg;
    logic               ready1;
    logic [COLOR_W-1:0] ca_reg;
    logic [COLOR_W-1:0] cb_reg;
    logic [F:0]         w_reg;
    logic [F:0]         wi_reg;

    // stage 2: products
    logic               v2_reg;
    logic               ready2;
    logic [PROD_W-1:0]  pa_reg [NUM_CHAN];
    logic [PROD_W-1:0]  pb_reg [NUM_CHAN];

    // stage 3: output register
    logic               v3_reg;
    logic               ready3;
    logic [COLOR_W-1:0] rgb_reg;
    logic [COLOR_W-1:0] rgb_next;
    logic [PROD_W:0]    sum [NUM_CHAN];

    always_comb begin
        if (in_flags.zero) begin
            q = '0;
        end else if (in_flags.sat) begin
            q = {1'b1, {(F+1){1'b0}}};
        end else begin
            q = {1'b0, in_quo};
        end
    end

    assign upper   = q[F+1] | q[F];
    // upper half weight is q - 1.0; only the clamped top has bit F+1 set
    assign w_next  = upper ? {q[F+1], q[F-1:0]} : q[F:0];
    assign wi_full = {2'b01, {F{1'b0}}} - {1'b0, w_next};

    assign ready3   = !v3_reg || out_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= in_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && in_valid) begin
            ca_reg <= upper ? colors.mid : colors.low;
            cb_reg <= upper ? colors.high : colors.mid;
            w_reg  <= w_next;
            wi_reg <= wi_full[F:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ready2 && v1_reg) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                pa_reg[c] <= PROD_W'(ca_reg[c*CHAN_W +: CHAN_W]) * PROD_W'(wi_reg);
                pb_reg[c] <= PROD_W'(cb_reg[c*CHAN_W +: CHAN_W]) * PROD_W'(w_reg);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            sum[c] = {1'b0, pa_reg[c]} + {1'b0, pb_reg[c]};
            rgb_next[c*CHAN_W +: CHAN_W] = sum[c][F +: CHAN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (ready3 && v2_reg) begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_rgb   = rgb_reg;

endmodule

### verif/testbench.sv
// Testbench for height_color_ramp: directed and random heights, checked against a ramp predictor.
`timescale 1ns / 100ps

module testbench;
    import hcr_pkg::*;

    localparam int PIPE_LATENCY = 22;
    localparam int RANDOM_ITEMS = 1100;
    localparam int PHASE_ITEMS  = 50;
    localparam longint ONE_FX   = 64'sd65536;

    // indexes past the last register; writes there must change nothing
    localparam cfg_idx_t REG_SPARE_LO = 3'd5;
    localparam cfg_idx_t REG_SPARE_HI = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_idx_t    cfg_index = REG_HEIGHT_MIN;
    logic [23:0] cfg_data = '0;

    // predictor copy of the register file
    logic signed [15:0]  ramp_lo = '0;
    logic signed [15:0]  ramp_hi = '0;
    logic [COLOR_W-1:0]  col_low  = COLOR_LOW_RST;
    logic [COLOR_W-1:0]  col_mid  = COLOR_MID_RST;
    logic [COLOR_W-1:0]  col_high = COLOR_HIGH_RST;

    logic [COLOR_W-1:0]  expected_rgb[$];
    int                  fail_count = 0;

    // sender and receiver pacing
    bit tx_dense = 1'b0;
    int tx_burst = 1;
    bit rx_free  = 1'b1;
    int rx_hold  = 0;

    height_color_ramp u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [15:0] height
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [23:0] rgb
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic logic [COLOR_W-1:0] blend_rgb(input logic [COLOR_W-1:0] ca,
                                                     input logic [COLOR_W-1:0] cb,
                                                     input longint w);
        logic [COLOR_W-1:0] res;
        longint a, b;
        res = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            a = ca[c*CHAN_W +: CHAN_W];
            b = cb[c*CHAN_W +: CHAN_W];
            res[c*CHAN_W +: CHAN_W] = 8'((a * (ONE_FX - w) + b * w) >>> 16);
        end
        return res;
    endfunction

    function automatic logic [COLOR_W-1:0] ramp_color(input logic signed [15:0] height);
        longint z, lo, hi, q;
        z  = height;
        lo = ramp_lo;
        hi = ramp_hi;
        if (lo == hi)
            return col_low;
        // C-style division, truncating toward zero for either sign
        q = (2 * (z - lo) * ONE_FX) / (hi - lo);
        if (q < 0)
            q = 0;
        else if (q > 2 * ONE_FX)
            q = 2 * ONE_FX;
        if (q < ONE_FX)
            return blend_rgb(col_low, col_mid, q);
        return blend_rgb(col_mid, col_high, q - ONE_FX);
    endfunction

    // result checker
    always @(posedge aclk) begin : check_rgb
        logic [COLOR_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_rgb.size() == 0) begin
                $error("rgb: unexpected transfer, expected none, actual %06h", m_tdata);
                fail_count++;
            end else begin
                want = expected_rgb.pop_front();
                if (m_tdata !== want) begin
                    $error("rgb: expected %06h, actual %06h", want, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    // receiver back pressure: alternating ready and stall stretches of random length, or always ready while rx_free
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (rx_free) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= !m_tready;
            rx_hold  <= m_tready ? $urandom_range(0, 20) : $urandom_range(0, 6);
        end
    end

    task automatic send_height(input logic signed [15:0] height);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= height;
        do @(posedge aclk); while (!s_tready);
        expected_rgb.push_back(ramp_color(height));
        tx_burst--;
        if (tx_burst <= 0) begin
            tx_burst = $urandom_range(1, 16);
            if (!tx_dense) begin
                gap = $urandom_range(1, 12);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_rgb.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_HEIGHT_MIN: ramp_lo  = data[15:0];
            REG_HEIGHT_MAX: ramp_hi  = data[15:0];
            REG_COLOR_LOW:  col_low  = data;
            REG_COLOR_MID:  col_mid  = data;
            REG_COLOR_HIGH: col_high = data;
            default: ;
        endcase
    endtask

    // loads a full ramp once the pipeline is empty; upper data bits of heights are junk
    task automatic set_ramp(input int lo, input int hi, input logic [23:0] cl,
                            input logic [23:0] cm, input logic [23:0] ch);
        wait_drained();
        write_reg(REG_HEIGHT_MIN, {8'($urandom), 16'(lo)});
        write_reg(REG_HEIGHT_MAX, {8'($urandom), 16'(hi)});
        write_reg(REG_COLOR_LOW, cl);
        write_reg(REG_COLOR_MID, cm);
        write_reg(REG_COLOR_HIGH, ch);
        if ($urandom_range(0, 2) == 0)
            write_reg(cfg_idx_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 24'($urandom));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_values();
        // both limits reset to zero, so every height gives the low color
        send_height(-16'sd32768);
        send_height(16'sd0);
        send_height(16'sd32767);
    endtask

    task automatic test_directed_ramps();
        set_ramp(-32768, 32767, 24'h102030, 24'h80FF00, 24'hFFFFFF);
        send_height(-16'sd32768);
        send_height(16'sd32767);
        send_height(-16'sd1);
        send_height(16'sd0);
        send_height(16'sd16384);

        set_ramp(-100, 100, 24'hFFFFFF, 24'h000000, 24'h00FF80);
        write_reg(REG_SPARE_HI, 24'hFFFFFF);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        send_height(16'sd0);        // exact middle -> mid color
        send_height(-16'sd100);
        send_height(16'sd100);
        send_height(-16'sd101);
        send_height(16'sd101);
        send_height(16'sd50);
        send_height(-16'sd32768);
        send_height(16'sd32767);

        // inverted limits
        set_ramp(1000, -1000, 24'h0000FF, 24'hFF00FF, 24'hFF0000);
        send_height(16'sd1000);
        send_height(16'sd2000);
        send_height(-16'sd1000);
        send_height(-16'sd2000);
        send_height(16'sd0);

        // equal nonzero limits
        set_ramp(500, 500, 24'hABCDEF, 24'h123456, 24'h654321);
        send_height(16'sd500);
        send_height(-16'sd32768);

        // unit span, steepest possible ramp
        set_ramp(0, 1, 24'h000000, 24'h7F7F7F, 24'hFFFFFF);
        send_height(16'sd0);
        send_height(16'sd1);
    endtask

    function automatic logic [23:0] pick_color();
        case ($urandom_range(0, 5))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_random_ramps();
        int lo, hi, a, b, h, sent;
        sent = 0;
        for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
            case ($urandom_range(0, 7))
                0: begin lo = -32768; hi = 32767; end
                1: begin lo = 32767; hi = -32768; end
                2: begin lo = $urandom_range(0, 65535) - 32768; hi = lo; end
                3: begin
                    lo = $urandom_range(0, 65534) - 32768;
                    hi = lo + $urandom_range(1, 3);
                end
                4: begin
                    lo = $urandom_range(0, 65535) - 32768;
                    hi = lo + $urandom_range(0, 400) - 200;
                    if (hi > 32767) hi = 32767;
                    if (hi < -32768) hi = -32768;
                end
                default: begin
                    lo = $urandom_range(0, 65535) - 32768;
                    hi = $urandom_range(0, 65535) - 32768;
                end
            endcase
            set_ramp(lo, hi, pick_color(), pick_color(), pick_color());
            tx_dense = (phase % 4 == 1);
            rx_free  = (phase % 3 == 0);
            a = (lo < hi) ? lo : hi;
            b = (lo < hi) ? hi : lo;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 9) < 7) begin
                    h = a - 4 + int'($urandom_range(0, b - a + 8));
                    if (h > 32767) h = 32767;
                    if (h < -32768) h = -32768;
                end else begin
                    h = int'($urandom_range(0, 65535)) - 32768;
                end
                send_height(16'(h));
            end
            sent += PHASE_ITEMS;
        end
    endtask

    task automatic test_drain_pause();
        // stop the sender until the pipeline is empty, then resume with the same ramp
        tx_dense = 1'b1;
        rx_free  = 1'b0;
        for (int i = 0; i < 30; i++)
            send_height(16'($urandom));
        wait_drained();
        for (int i = 0; i < 30; i++)
            send_height(16'($urandom));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_directed_ramps();
        test_random_ramps();
        test_drain_pause();
        wait_drained();
        repeat (PIPE_LATENCY + 10) @(posedge aclk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
